>>> sv/utf8_to_ucs2_decoder_assert.svh
// Assertion macros for the UTF-8 to UCS-2 decoder.
// Used by the top level only; no other dependencies.
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define U8DEC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8dec assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define U8DEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8dec assertion failed: next-cycle check");

`endif

>>> sv/u8dec_pkg.sv
// Shared types, constants and lead-byte decode for the UTF-8 decoder.
// No dependencies.
`default_nettype none

package u8dec_pkg;

   localparam int ByteW = 8;
   localparam int CodeW = 16;
   localparam int LeftW = 3;

   localparam logic [LeftW-1:0] MaxLeft = 3'd5;

   // One decoder result headed for the output register.
   typedef struct packed {
      logic             valid;
      logic [CodeW-1:0] code_unit;
      logic             status;
   } result_type;

   // Classification of a byte seen as a lead byte.
   typedef struct packed {
      logic             single;   // yields a result by itself
      logic             err;      // invalid lead
      logic [CodeW-1:0] code;     // result code or initial accumulator
      logic [LeftW-1:0] left;     // continuation bytes due
   } lead_type;

   // Internal status exported for checking.
   typedef struct packed {
      logic [LeftW-1:0] bytes_left;
   } mon_type;

   function automatic lead_type lead_decode(input logic [ByteW-1:0] b);
      lead_type r;
      r = '0;
      case (b) inside
         [8'h00:8'h7F]: begin
            r.single = 1'b1;
            r.code   = {8'h00, b};
         end
         [8'hC0:8'hDF]: begin
            r.code = {11'd0, b[4:0]};
            r.left = 3'd1;
         end
         [8'hE0:8'hEF]: begin
            r.code = {12'd0, b[3:0]};
            r.left = 3'd2;
         end
         [8'hF0:8'hF7]: begin
            r.code = {13'd0, b[2:0]};
            r.left = 3'd3;
         end
         [8'hF8:8'hFB]: begin
            r.code = {14'd0, b[1:0]};
            r.left = 3'd4;
         end
         [8'hFC:8'hFD]: begin
            r.code = {15'd0, b[0]};
            r.left = MaxLeft;
         end
         default: begin
            // stray continuation, 0xFE, 0xFF
            r.single = 1'b1;
            r.err    = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/u8dec_in_reg.sv
// Input register for the UTF-8 decoder: holds one byte transaction.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_in_reg
   import u8dec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ByteW-1:0] req_in_byte,
   input  wire logic             advance,
   output logic                  item_valid,
   output logic [ByteW-1:0]      item_byte
);

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] byte_ff;
   logic             accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

`default_nettype wire

>>> sv/u8dec_step.sv
// Decode step: sequence state and the per-byte update of the UTF-8 decoder.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_step
   import u8dec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [ByteW-1:0] item_byte,
   output result_type            result,
   output mon_type               mon
);

   logic [LeftW-1:0] bytes_left_ff, bytes_left_in;
   logic [CodeW-1:0] accum_ff, accum_in;
   lead_type         lead;
   logic [CodeW-1:0] accum_shift;
   logic             is_cont;

   assign lead        = lead_decode(item_byte);
   assign is_cont     = (item_byte[7:6] == 2'b10);
   assign accum_shift = {accum_ff[CodeW-7:0], item_byte[5:0]};

   always_comb begin
      bytes_left_in    = bytes_left_ff;
      accum_in         = accum_ff;
      result           = '0;
      if (bytes_left_ff == '0) begin
         if (lead.single) begin
            result.valid     = 1'b1;
            result.code_unit = lead.code;
            result.status    = lead.err;
         end else begin
            accum_in      = lead.code;
            bytes_left_in = lead.left;
         end
      end else if (is_cont) begin
         accum_in      = accum_shift;
         bytes_left_in = bytes_left_ff - 3'd1;
         if (bytes_left_ff == 3'd1) begin
            result.valid     = 1'b1;
            result.code_unit = accum_shift;
         end
      end else begin
         // bad continuation: flag it, then restart on this byte
         result.valid  = 1'b1;
         result.status = 1'b1;
         if (lead.single) begin
            accum_in      = '0;
            bytes_left_in = '0;
         end else begin
            accum_in      = lead.code;
            bytes_left_in = lead.left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         accum_ff      <= '0;
      end else if (advance) begin
         bytes_left_ff <= bytes_left_in;
         accum_ff      <= accum_in;
      end
   end

   assign mon.bytes_left = bytes_left_ff;

endmodule

`default_nettype wire

>>> sv/u8dec_out_reg.sv
// Result register for the UTF-8 decoder: holds one result transaction.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_out_reg
   import u8dec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire result_type  result,
   output logic             out_free,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [CodeW-1:0] rsp_code_unit,
   output logic             rsp_status
);

   logic             valid_ff, valid_in;
   logic [CodeW-1:0] code_ff;
   logic             status_ff;
   logic             load;

   assign out_free = !valid_ff || !rsp_stall;
   assign load     = advance && result.valid;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff   <= result.code_unit;
         status_ff <= result.status;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_code_unit = code_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

>>> sv/utf8_to_ucs2_decoder.sv
// UTF-8 to UCS-2 decoder, top level. Depends on u8dec_pkg, u8dec_in_reg,
// u8dec_step, u8dec_out_reg and utf8_to_ucs2_decoder_assert.svh.
// Bytes pass the input register, decode step and result register in turn.
// Throughput: one byte per cycle while the result register is free; the
// only loop is the 3-bit count and 16-bit accumulator update in the step.
// Reset (synchronous, active high) empties both registers and returns the
// decoder to idle with a zero accumulator.
`default_nettype none

`include "utf8_to_ucs2_decoder_assert.svh"

module utf8_to_ucs2_decoder
   import u8dec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // byte transactions in
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ByteW-1:0] req_in_byte,
   // code unit transactions out
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [CodeW-1:0]      rsp_code_unit,
   output logic                  rsp_status
);

   logic             item_valid;
   logic [ByteW-1:0] item_byte;
   logic             advance;
   logic             out_free;
   result_type       result;
   mon_type          mon;

   // A held byte moves through the decode step whenever the result register
   // can take a result. Bytes that produce nothing (leads, middle continuation
   // bytes) still need the free slot; keeps the control simple and costs
   // nothing while results are drained.
   assign advance = item_valid && out_free;

   u8dec_in_reg u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   // Sequence state lives here and only changes on advance, so the next byte
   // (already in the input register) sees the updated count next cycle.
   u8dec_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item_byte (item_byte),
      .result    (result),
      .mon       (mon)
   );

   u8dec_out_reg u_out (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .result        (result),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_unit (rsp_code_unit),
      .rsp_status    (rsp_status)
   );

   // Count never exceeds the six-byte lead form.
   `U8DEC_ASSERT_IMP(a_left_range, clock, reset, 1'b1, mon.bytes_left <= MaxLeft)
   // Error transactions always carry a zero code unit.
   `U8DEC_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_status, rsp_code_unit == '0)
   // A new result only appears after a byte went through the decode step.
   `U8DEC_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid), $past(advance))
   // An accepted byte is held in the input register next cycle.
   `U8DEC_ASSERT_NEXT(a_accept_held, clock, reset, req_valid && !req_stall, item_valid)

endmodule

`default_nettype wire

>>> verif/utf8_to_ucs2_decoder_tb.sv
// Self-checking testbench for the UTF-8 to UCS-2 decoder (utf8_to_ucs2_decoder).
// Directed and random byte streams under random idling; results are checked
// against an in-bench decoder model. Depends on u8dec_pkg and the RTL only.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_tb;
   import u8dec_pkg::*;

   // Byte classes of the UTF-8 stream.
   localparam logic [ByteW-1:0] CONT_LO  = 8'h80;   // first continuation byte
   localparam logic [ByteW-1:0] CONT_HI  = 8'hBF;   // last continuation byte
   localparam logic [ByteW-1:0] LEAD2_LO = 8'hC0;
   localparam logic [ByteW-1:0] LEAD3_LO = 8'hE0;
   localparam logic [ByteW-1:0] LEAD4_LO = 8'hF0;
   localparam logic [ByteW-1:0] LEAD5_LO = 8'hF8;
   localparam logic [ByteW-1:0] LEAD6_LO = 8'hFC;
   localparam logic [ByteW-1:0] LEAD6_HI = 8'hFD;
   localparam logic [ByteW-1:0] MASK2    = 8'h1F;
   localparam logic [ByteW-1:0] MASK3    = 8'h0F;
   localparam logic [ByteW-1:0] MASK4    = 8'h07;
   localparam logic [ByteW-1:0] MASK5    = 8'h03;
   localparam logic [ByteW-1:0] MASK6    = 8'h01;

   localparam int N_ITEMS     = 1650;
   localparam int STALL_LIMIT = 2000;   // cycles with no transaction on either side
   localparam int DRAIN_WAIT  = 8;      // wait after the drain before the final check

   typedef enum logic {ST_OK = 1'b0, ST_BAD = 1'b1} status_type;

   typedef struct packed {
      logic [CodeW-1:0] code_unit;
      status_type       status;
   } code_unit_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [ByteW-1:0] req_in_byte = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [CodeW-1:0] rsp_code_unit;
   logic             rsp_status;

   logic [ByteW-1:0] byte_stream[$];      // bytes waiting to be offered
   code_unit_type    code_units_due[$];   // predicted results, oldest first

   // Model of the decoder state
   logic [LeftW-1:0] seq_left  = '0;
   logic [CodeW-1:0] seq_accum = '0;

   int unsigned tx_idle_pct = 7;
   int unsigned rx_idle_pct = 49;
   int          n_sent      = 0;
   int          mismatches  = 0;
   int          quiet_cycles = 0;

   utf8_to_ucs2_decoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_unit (rsp_code_unit),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Lead byte class: number of continuation bytes due (0 for ASCII and for
   // invalid leads) and the payload bits that seed the accumulator.
   function automatic void classify_lead(input logic [ByteW-1:0] b,
                                         output logic [LeftW-1:0] left,
                                         output logic [CodeW-1:0] payload);
      left    = '0;
      payload = '0;
      if (b >= LEAD2_LO && b < LEAD3_LO) begin
         left = 3'd1; payload = CodeW'(b & MASK2);
      end else if (b >= LEAD3_LO && b < LEAD4_LO) begin
         left = 3'd2; payload = CodeW'(b & MASK3);
      end else if (b >= LEAD4_LO && b < LEAD5_LO) begin
         left = 3'd3; payload = CodeW'(b & MASK4);
      end else if (b >= LEAD5_LO && b < LEAD6_LO) begin
         left = 3'd4; payload = CodeW'(b & MASK5);
      end else if (b >= LEAD6_LO && b <= LEAD6_HI) begin
         left = 3'd5; payload = CodeW'(b & MASK6);
      end
   endfunction

   // Advances the decoder model by one byte. Returns 1 when the byte yields
   // a result, which is then in res.
   function automatic logic decode_byte(input logic [ByteW-1:0] b,
                                        output code_unit_type res);
      logic [LeftW-1:0] left;
      logic [CodeW-1:0] payload;
      res = '{code_unit: '0, status: ST_OK};
      if (seq_left == '0) begin
         classify_lead(b, left, payload);
         if (left != '0) begin
            seq_left  = left;
            seq_accum = payload;
            return 1'b0;
         end
         // ASCII passes through, stray continuation / 0xFE / 0xFF is an error
         if (b < CONT_LO) res.code_unit = CodeW'(b);
         else res.status = ST_BAD;
         return 1'b1;
      end
      if (b >= CONT_LO && b <= CONT_HI) begin
         // shift in six payload bits, keep the low 16
         seq_accum = {seq_accum[CodeW-7:0], b[5:0]};
         seq_left  = seq_left - 3'd1;
         if (seq_left != '0) return 1'b0;
         res.code_unit = seq_accum;
         return 1'b1;
      end
      // Broken sequence: one error, then the byte restarts decoding. A
      // single-byte lead here is swallowed by the error result.
      classify_lead(b, left, payload);
      seq_left  = left;
      seq_accum = (left != '0) ? payload : '0;
      res.status = ST_BAD;
      return 1'b1;
   endfunction

   // Random lead byte of an n-byte sequence (n = 1 gives ASCII).
   function automatic logic [ByteW-1:0] rand_lead(input int n);
      case (n)
         1:       return ByteW'($urandom_range(CONT_LO - 1, 0));
         2:       return ByteW'($urandom_range(LEAD3_LO - 1, LEAD2_LO));
         3:       return ByteW'($urandom_range(LEAD4_LO - 1, LEAD3_LO));
         4:       return ByteW'($urandom_range(LEAD5_LO - 1, LEAD4_LO));
         5:       return ByteW'($urandom_range(LEAD6_LO - 1, LEAD5_LO));
         default: return ByteW'($urandom_range(LEAD6_HI, LEAD6_LO));
      endcase
   endfunction

   function automatic logic [ByteW-1:0] rand_cont();
      return ByteW'($urandom_range(CONT_HI, CONT_LO));
   endfunction

   // Driver: offers the next queued byte unless it decides to idle this
   // cycle. A byte under stall is held; the model advances on acceptance.
   always @(posedge clock) begin : drive_req
      code_unit_type res;
      logic          load;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         load = !req_valid;
         if (req_valid && !req_stall) begin
            if (decode_byte(req_in_byte, res)) code_units_due.push_back(res);
            n_sent++;
            load = 1'b1;
         end
         if (load) begin
            if (byte_stream.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_valid   <= 1'b1;
               req_in_byte <= byte_stream.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random backpressure, and each accepted result is checked
   // field by field against the oldest prediction.
   always @(posedge clock) begin : watch_rsp
      code_unit_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (code_units_due.size() == 0) begin
               report_mismatch($sformatf("result %h/%0d with none due",
                                         rsp_code_unit, rsp_status));
            end else begin
               want = code_units_due.pop_front();
               if (rsp_code_unit !== want.code_unit)
                  report_mismatch($sformatf("code_unit %h, want %h",
                                            rsp_code_unit, want.code_unit));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %b, want %b",
                                            rsp_status, want.status));
            end
         end
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Watchdog: ends a run in which no transaction moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("utf8_to_ucs2_decoder test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int n, pick, total;
      logic [ByteW-1:0] b;

      // Directed part:
      //  zero byte, top ASCII, stray continuation and the two never-valid bytes
      byte_stream = {8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFE};
      //  3-byte euro sign
      byte_stream = {byte_stream, 8'hE2, 8'h82, 8'hAC};
      //  6-byte old form, all payload bits set in the lead
      byte_stream = {byte_stream, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
      //  broken 3-byte sequence; the ASCII byte is absorbed into the error
      byte_stream = {byte_stream, 8'hE2, 8'h41};
      //  broken 2-byte sequence; an invalid lead is absorbed too
      byte_stream = {byte_stream, 8'hC3, 8'hFF};
      //  broken 2-byte sequence whose breaker starts a 5-byte old form
      byte_stream = {byte_stream, 8'hC3, 8'hF8, 8'h88, 8'h80, 8'h80, 8'h80};

      // Random part: mostly well-formed sequences of every length, some cut
      // short by a non-continuation byte, some raw noise.
      while (byte_stream.size() < N_ITEMS) begin
         pick = $urandom_range(99);
         n    = $urandom_range(6, 1);
         if (pick < 80) begin
            byte_stream.push_back(rand_lead(n));
            repeat (n - 1) byte_stream.push_back(rand_cont());
         end else if (pick < 90) begin
            n = $urandom_range(6, 2);
            byte_stream.push_back(rand_lead(n));
            repeat ($urandom_range(n - 2, 0)) byte_stream.push_back(rand_cont());
            do b = ByteW'($urandom_range(255));
            while (b >= CONT_LO && b <= CONT_HI);
            byte_stream.push_back(b);
         end else begin
            byte_stream.push_back(ByteW'($urandom_range(255)));
         end
      end
      total = byte_stream.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Idling phases: slow receiver, then slow sender, then full rate.
      while (n_sent < total / 3) @(posedge clock);
      tx_idle_pct <= 49;
      rx_idle_pct <= 7;
      while (n_sent < 2 * total / 3) @(posedge clock);
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;

      // Drain: all bytes accepted and every predicted result seen.
      while (byte_stream.size() > 0 || req_valid || code_units_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (code_units_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", code_units_due.size()));

      if (mismatches == 0) begin
         $display("utf8_to_ucs2_decoder test passed");
      end else begin
         $display("utf8_to_ucs2_decoder test failed");
      end
      $finish;
   end

endmodule
